// ----- hw/rtl/wildcard_glob_matcher_assert.svh -----
// Assertion macros for the wildcard glob matcher.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define GWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gwm same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define GWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gwm next-cycle check failed");
`else
`define GWM_ASSERT_NOW(lbl, ante, cons)
`define GWM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/gwm_pkg.sv -----
// Shared types, constants and helpers for the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 128;

  localparam logic [7:0] CH_ANY      = 8'h3F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_item_t;

  // Registered input item as seen by the work stage.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Fold ASCII A-Z to a-z.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gwm_in_reg.sv -----
// Input register stage of the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none

module gwm_in_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gwm_pkg::in_item_t in_data,
  input  wire logic             go,
  output gwm_pkg::stage_t       s1
);

  logic              valid_r;
  gwm_pkg::in_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (go) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_valid) begin
      item_r <= in_data;
    end
  end

  // Hold the upstream side only while the staged item cannot move on.
  assign in_stall = valid_r & ~go;

  assign s1.valid = valid_r;
  assign s1.item  = item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gwm_pattern.sv -----
// Pattern store: folded bytes, wildcard masks, length, overflow and leading-star set.
`timescale 1ns / 1ps
`default_nettype none

module gwm_pattern #(
  parameter  int unsigned PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
  localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1),
  localparam int unsigned IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gwm_pkg::stage_t             op,
  input  wire logic                        fire,
  output logic [PATTERN_MAX-1:0]           star_mask,
  output logic [PATTERN_MAX-1:0]           any_mask,
  output logic [PATTERN_MAX-1:0]           live_mask,
  output logic [PATTERN_MAX-1:0][7:0]      chars,
  output logic [LEN_W-1:0]                 len,
  output logic                             overflow,
  output logic [PATTERN_MAX:0]             lead_nxt
);

  localparam logic [PATTERN_MAX:0] LEAD_RESET = (PATTERN_MAX + 1)'(1);

  logic [PATTERN_MAX-1:0][7:0] chars_r;
  logic [PATTERN_MAX-1:0]      star_r;
  logic [PATTERN_MAX-1:0]      any_r;
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [PATTERN_MAX:0]        lead_r;

  logic             do_clear;
  logic             do_app;
  logic             has_room;
  logic             in_star;
  logic [LEN_W-1:0] slot;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    do_clear = fire && (op.item.command == gwm_pkg::CMD_CLEAR);
    do_app   = fire && (op.item.command == gwm_pkg::CMD_APPEND);
    has_room = len_r < LEN_W'(PATTERN_MAX);
    in_star  = op.item.char_code == gwm_pkg::CH_STAR;
    slot     = len_r + LEN_W'(1);
    wr_idx   = len_r[IDX_W-1:0];
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    lead_nxt = lead_r;
    if (do_clear) begin
      len_nxt  = '0;
      ovf_nxt  = 1'b0;
      lead_nxt = LEAD_RESET;
    end else if (do_app) begin
      if (has_room) begin
        len_nxt = slot;
        // Extend the leading run of stars when the new byte continues it.
        lead_nxt[slot] = lead_r[len_r] & in_star;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      lead_r <= LEAD_RESET;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      lead_r <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_app && has_room) begin
      chars_r[wr_idx] <= gwm_pkg::fold(op.item.char_code);
      star_r[wr_idx]  <= in_star;
      any_r[wr_idx]   <= op.item.char_code == gwm_pkg::CH_ANY;
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      live_mask[i] = LEN_W'(i) < len_r;
    end
  end

  assign star_mask = star_r;
  assign any_mask  = any_r;
  assign chars     = chars_r;
  assign len       = len_r;
  assign overflow  = ovf_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gwm_match.sv -----
// Active position set update with star closure, and the result register.
`timescale 1ns / 1ps
`default_nettype none

module gwm_match #(
  parameter  int unsigned PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
  localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gwm_pkg::stage_t             op,
  input  wire logic [PATTERN_MAX-1:0]      star_mask,
  input  wire logic [PATTERN_MAX-1:0]      any_mask,
  input  wire logic [PATTERN_MAX-1:0]      live_mask,
  input  wire logic [PATTERN_MAX-1:0][7:0] chars,
  input  wire logic [LEN_W-1:0]            len,
  input  wire logic                        overflow,
  input  wire logic [PATTERN_MAX:0]        lead_nxt,
  output logic                             go,
  output logic                             fire,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output gwm_pkg::out_item_t               out_data
);

  // Kept closed over stars at all times.
  logic [PATTERN_MAX:0]   active_r, active_nxt;
  logic                   out_valid_r;
  gwm_pkg::out_item_t     out_data_r;

  logic [7:0]             fc;
  logic [PATTERN_MAX-1:0] stars;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX:0]   step;
  logic [PATTERN_MAX:0]   prop;
  logic [PATTERN_MAX:0]   closed;
  logic                   is_end;

  always_comb begin
    is_end = op.valid && (op.item.command == gwm_pkg::CMD_END);
    go     = !is_end || !out_valid_r || !out_stall;
    fire   = op.valid && go;
  end

  always_comb begin
    fc    = gwm_pkg::fold(op.item.char_code);
    stars = star_mask & live_mask;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      hit[i] = active_r[i] & live_mask[i] & ~star_mask[i] &
               (any_mask[i] | (chars[i] == fc));
    end
    // Stars keep their position; other matches advance by one.
    step = {hit, 1'b0} | {1'b0, active_r[PATTERN_MAX-1:0] & stars};
    // Star closure as a carry chain through runs of star positions.
    prop   = {1'b0, stars};
    closed = step | (((step & prop) + prop) ^ prop);
  end

  always_comb begin
    active_nxt = active_r;
    if (fire) begin
      unique case (op.item.command)
        gwm_pkg::CMD_TEXT:   active_nxt = closed;
        gwm_pkg::CMD_CLEAR,
        gwm_pkg::CMD_APPEND,
        gwm_pkg::CMD_END:    active_nxt = lead_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= (PATTERN_MAX + 1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (fire && is_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_end) begin
      out_data_r.matched          <= active_r[len];
      out_data_r.pattern_overflow <= overflow;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/wildcard_glob_matcher.sv -----
// Top level of the case-insensitive wildcard glob matcher.
//
// Input channel (in_valid / in_stall / in_data) carries commands: clear the
// pattern, append a pattern byte, feed a text byte, or end the text. Only the
// end-of-text command yields a result on the output channel (out_valid /
// out_stall / out_data): whether the whole text matched the whole pattern,
// and whether pattern bytes were dropped since the last clear.
// A new item is taken every cycle unless an end-of-text item is blocked in
// the input register. The result is registered: the end-of-text transfer
// loads the input register, and once that item fires in the work stage the
// result register is loaded and out_valid rises. The work stage's logic is
// bounded by the folded byte compare plus the star-closure carry chain
// across PATTERN_MAX + 1 positions.
// Reset empties the pattern, clears the overflow flag and arms a new text;
// pattern bytes are never cleared, only the length is.
// While the receiver stalls a pending result, non-result commands still pass
// through; an end-of-text item waits in the input register and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

`include "wildcard_glob_matcher_assert.svh"

module wildcard_glob_matcher #(
  parameter int unsigned PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gwm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gwm_pkg::out_item_t      out_data
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  gwm_pkg::stage_t             s1;
  logic                        go;
  logic                        fire;
  logic [PATTERN_MAX-1:0]      star_mask;
  logic [PATTERN_MAX-1:0]      any_mask;
  logic [PATTERN_MAX-1:0]      live_mask;
  logic [PATTERN_MAX-1:0][7:0] chars;
  logic [LEN_W-1:0]            pat_len;
  logic                        overflow;
  logic [PATTERN_MAX:0]        lead_nxt;
  logic                        end_blocked;

  gwm_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .go       (go),
    .s1       (s1)
  );

  gwm_pattern #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (s1),
    .fire      (fire),
    .star_mask (star_mask),
    .any_mask  (any_mask),
    .live_mask (live_mask),
    .chars     (chars),
    .len       (pat_len),
    .overflow  (overflow),
    .lead_nxt  (lead_nxt)
  );

  gwm_match #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (s1),
    .star_mask (star_mask),
    .any_mask  (any_mask),
    .live_mask (live_mask),
    .chars     (chars),
    .len       (pat_len),
    .overflow  (overflow),
    .lead_nxt  (lead_nxt),
    .go        (go),
    .fire      (fire),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign end_blocked = s1.valid && (s1.item.command == gwm_pkg::CMD_END) &&
                       out_valid && out_stall;

  // Only a blocked end-of-text item may hold the input side.
  `GWM_ASSERT_NOW(a_stall_cause, in_stall, end_blocked)
  // A processed end-of-text item always presents a result next cycle.
  `GWM_ASSERT_NEXT(a_end_result, fire && s1.item.command == gwm_pkg::CMD_END, out_valid)
  // A clear empties the pattern.
  `GWM_ASSERT_NEXT(a_clear_len, fire && s1.item.command == gwm_pkg::CMD_CLEAR, pat_len == '0)
  // The stored length never passes the store size.
  `GWM_ASSERT_NOW(a_len_bound, 1'b1, pat_len <= LEN_W'(PATTERN_MAX))

endmodule

`default_nettype wire

// ----- verif/wildcard_glob_matcher_tb.sv -----
// Self-checking testbench for the case-insensitive wildcard glob matcher.
`timescale 1ns / 1ps

module wildcard_glob_matcher_tb;

  localparam int unsigned PAT_MAX      = gwm_pkg::PATTERN_MAX_DEF;
  localparam int          N_DIRECTED   = 26;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          IDLE_LIMIT   = 3000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          HOLD_AFTER   = 40;
  localparam int          DRAIN_CYCLES = 20;
  localparam logic [PAT_MAX:0] LIVE_RESET = (PAT_MAX + 1)'(1);

  typedef struct packed {
    gwm_pkg::in_item_t  item;
    logic               pinned;
    gwm_pkg::out_item_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  gwm_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  gwm_pkg::out_item_t out_data;

  // Pattern state tracked alongside the block.
  logic [7:0]       pat_bytes [PAT_MAX];
  int unsigned      pat_len;
  logic             pat_ovf;
  logic [PAT_MAX:0] live_pos;

  gwm_pkg::out_item_t verdict_q [$];
  int        items_sent   = 0;
  int        results_seen = 0;
  int        miss_count   = 0;
  int        idle_cycles  = 0;
  int        burst_left   = 0;

  // Pinned rows carry a verdict that is obvious from the rules alone.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{gwm_pkg::CMD_END,    8'h00},            1'b1, '{1'b1, 1'b0}},
    '{'{gwm_pkg::CMD_TEXT,   8'hFF},            1'b0, '0},
    '{'{gwm_pkg::CMD_END,    8'hFF},            1'b1, '{1'b0, 1'b0}},
    '{'{gwm_pkg::CMD_APPEND, gwm_pkg::CH_STAR}, 1'b0, '0},
    '{'{gwm_pkg::CMD_APPEND, gwm_pkg::CH_STAR}, 1'b0, '0},
    '{'{gwm_pkg::CMD_END,    8'h00},            1'b1, '{1'b1, 1'b0}},
    '{'{gwm_pkg::CMD_APPEND, 8'h5A},            1'b0, '0},
    '{'{gwm_pkg::CMD_APPEND, gwm_pkg::CH_ANY},  1'b0, '0},
    '{'{gwm_pkg::CMD_APPEND, 8'h00},            1'b0, '0},
    '{'{gwm_pkg::CMD_APPEND, 8'hFF},            1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   8'h41},            1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   8'h7A},            1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   gwm_pkg::CH_ANY},  1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   8'h00},            1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   8'hFF},            1'b0, '0},
    '{'{gwm_pkg::CMD_END,    8'h00},            1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   8'h5A},            1'b0, '0},
    '{'{gwm_pkg::CMD_APPEND, 8'h40},            1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   gwm_pkg::CH_STAR}, 1'b0, '0},
    '{'{gwm_pkg::CMD_END,    8'h00},            1'b0, '0},
    '{'{gwm_pkg::CMD_CLEAR,  8'hFF},            1'b0, '0},
    '{'{gwm_pkg::CMD_APPEND, 8'h5B},            1'b0, '0},
    '{'{gwm_pkg::CMD_TEXT,   8'h7B},            1'b0, '0},
    '{'{gwm_pkg::CMD_END,    8'h00},            1'b0, '0},
    '{'{gwm_pkg::CMD_CLEAR,  8'h00},            1'b0, '0},
    '{'{gwm_pkg::CMD_END,    8'h55},            1'b1, '{1'b1, 1'b0}}
  };

  wildcard_glob_matcher u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic is_upper;
    is_upper = (c >= "A") && (c <= "Z");
    return is_upper ? (c | 8'h20) : c;
  endfunction

  // A star at a live position also makes the following position live.
  function automatic logic [PAT_MAX:0] star_close(input logic [PAT_MAX:0] s);
    logic [PAT_MAX:0] r;
    r = s;
    for (int i = 0; i < pat_len; i++) begin
      if (r[i] && pat_bytes[i] == gwm_pkg::CH_STAR) r[i + 1] = 1'b1;
    end
    return r;
  endfunction

  task automatic glob_predict(input gwm_pkg::cmd_t c, input logic [7:0] ch,
                              output logic has_verdict,
                              output gwm_pkg::out_item_t verdict);
    logic [PAT_MAX:0] cur;
    logic [PAT_MAX:0] nxt;
    has_verdict = 1'b0;
    verdict     = '0;
    case (c)
      gwm_pkg::CMD_CLEAR: begin
        pat_len  = 0;
        pat_ovf  = 1'b0;
        live_pos = LIVE_RESET;
      end
      gwm_pkg::CMD_APPEND: begin
        if (pat_len < PAT_MAX) begin
          pat_bytes[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        live_pos = LIVE_RESET;
      end
      gwm_pkg::CMD_TEXT: begin
        cur = star_close(live_pos);
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (cur[i]) begin
            if (pat_bytes[i] == gwm_pkg::CH_STAR) begin
              nxt[i] = 1'b1;
            end else if (pat_bytes[i] == gwm_pkg::CH_ANY ||
                         fold_case(pat_bytes[i]) == fold_case(ch)) begin
              nxt[i + 1] = 1'b1;
            end
          end
        end
        live_pos = star_close(nxt);
      end
      default: begin
        cur = star_close(live_pos);
        verdict.matched          = cur[pat_len];
        verdict.pattern_overflow = pat_ovf;
        has_verdict              = 1'b1;
        live_pos                 = LIVE_RESET;
      end
    endcase
  endtask

  function automatic logic [7:0] pick_pat_byte();
    case ($urandom_range(0, 9))
      0, 1:    return gwm_pkg::CH_STAR;
      2:       return gwm_pkg::CH_ANY;
      3:       return "a";
      4:       return "B";
      5:       return "b";
      6:       return "A";
      7:       return "c";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 7))
      0:       return "a";
      1:       return "A";
      2:       return "b";
      3:       return "B";
      4:       return "c";
      5:       return "x";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one item in bursts with random gaps; predict once it transfers.
  task automatic send_item(input gwm_pkg::cmd_t c, input logic [7:0] ch,
                           input logic pinned, input gwm_pkg::out_item_t pinned_res);
    gwm_pkg::in_item_t  it;
    logic               has_v;
    gwm_pkg::out_item_t v;
    int                 gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.command   = c;
    it.char_code = ch;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    glob_predict(c, ch, has_v, v);
    if (has_v) verdict_q.insert(verdict_q.size(), pinned ? pinned_res : v);
    items_sent++;
  endtask

  function automatic logic count_miss();
    miss_count++;
    return miss_count <= 10;
  endfunction

  always @(posedge clk) begin : result_check
    gwm_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        if (count_miss())
          $display("unexpected result: matched=%0b pattern_overflow=%0b",
                   out_data.matched, out_data.pattern_overflow);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.matched !== want.matched ||
            out_data.pattern_overflow !== want.pattern_overflow) begin
          if (count_miss())
            $display("result mismatch (matched/pattern_overflow): expected %0b/%0b, got %0b/%0b",
                     want.matched, want.pattern_overflow,
                     out_data.matched, out_data.pattern_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("wildcard_glob_matcher_tb failed");
        $finish;
      end
    end
  end

  // Receiver: stall in modes of varying density, with one long hold-off.
  initial begin : result_stall
    int   mode;
    int   span;
    logic held;
    mode = 0;
    span = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [7:0] text_q [$];
    logic [7:0] b;
    int         seq_no;
    int         plen;
    int         ntexts;
    logic       long_pat;
    seq_no   = 0;
    pat_len  = 0;
    pat_ovf  = 1'b0;
    live_pos = LIVE_RESET;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item.command, directed_rows[i].item.char_code,
                directed_rows[i].pinned, directed_rows[i].want);

    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      seq_no++;
      if ($urandom_range(0, 7) == 0) begin
        // noise: arbitrary commands and bytes
        repeat ($urandom_range(1, 4))
          send_item(gwm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'b0, '0);
      end else begin
        long_pat = (seq_no == 3) || ($urandom_range(0, 39) == 0);
        if (seq_no == 3) plen = PAT_MAX + 3;
        else if (long_pat) plen = $urandom_range(PAT_MAX - 4, PAT_MAX + 8);
        else plen = $urandom_range(0, 8);
        if (long_pat || $urandom_range(0, 3) != 0) begin
          // skipping the clear now and then lets the pattern grow across sequences
          if (long_pat || $urandom_range(0, 9) != 0)
            send_item(gwm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
          repeat (plen) send_item(gwm_pkg::CMD_APPEND, pick_pat_byte(), 1'b0, '0);
        end
        ntexts = (pat_len > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
        repeat (ntexts) begin
          text_q.delete();
          for (int i = 0; i < pat_len; i++) begin
            b = pat_bytes[i];
            if (b == gwm_pkg::CH_STAR) begin
              repeat ($urandom_range(0, 3)) text_q.insert(text_q.size(), pick_text_byte());
            end else if (b == gwm_pkg::CH_ANY) begin
              text_q.insert(text_q.size(), pick_text_byte());
            end else begin
              if ($urandom_range(0, 1) == 0) begin
                if (b >= "a" && b <= "z") b = b - 8'h20;
                else if (b >= "A" && b <= "Z") b = b + 8'h20;
              end
              text_q.insert(text_q.size(), b);
            end
          end
          // break a third of the texts
          if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
              0: if (text_q.size() > 0)
                   text_q[$urandom_range(0, text_q.size() - 1)] = pick_text_byte();
              1: if (text_q.size() > 0) void'(text_q.pop_back());
              default: text_q.push_front(pick_text_byte());
            endcase
          end
          foreach (text_q[i]) send_item(gwm_pkg::CMD_TEXT, text_q[i], 1'b0, '0);
          if ($urandom_range(0, 19) == 0) begin
            // append in the middle of a text drops the text
            send_item(gwm_pkg::CMD_APPEND, pick_pat_byte(), 1'b0, '0);
            send_item(gwm_pkg::CMD_TEXT, pick_text_byte(), 1'b0, '0);
          end
          send_item(gwm_pkg::CMD_END, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (miss_count == 0) begin
      $display("wildcard_glob_matcher_tb passed");
    end else begin
      $display("wildcard_glob_matcher_tb failed");
    end
    $finish;
  end

endmodule
